// ===== rtl/upa_pkg.sv =====
// ----------------------------------------------------------------------------
// upa_pkg
// Shared types and codes of the process identifier allocator: beat
// structures, request and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package upa_pkg;

    // fixed field widths of the request and response beats
    localparam int PID_W  = 13;
    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;

    // request codes
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // response status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [PID_W-1:0] query_pid;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  result_pid;
        logic [SLOT_W-1:0] slot_index;
    } t_out_beat;

    // sequencer status toward the top level
    typedef struct packed {
        logic      idle;
        logic      res_valid;
        t_out_beat res;
    } t_ctrl_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_SCAN,
        S_LOOK,
        S_COMMIT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/upa_ram.sv =====
// ----------------------------------------------------------------------------
// upa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module upa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/upa_ctrl.sv =====
// ----------------------------------------------------------------------------
// upa_ctrl
// Request sequencer: owns the identifier table RAM, the fill count and the
// last-given / safe-bound counters, and walks the table one slot per cycle
// for rescans and lookups.
// ----------------------------------------------------------------------------
module upa_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int PID_LIMIT   = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  upa_pkg::t_in_beat   i_beat,
    input  logic                i_take,
    output upa_pkg::t_ctrl_stat o_stat
);
    import upa_pkg::*;

    localparam int AW         = $clog2(TABLE_DEPTH);
    localparam int CW         = $clog2(TABLE_DEPTH + 1);
    localparam int IDW        = $clog2(PID_LIMIT);
    localparam int LGW        = $clog2(PID_LIMIT + 2);
    localparam int SCAN_BOUND = 2 * PID_LIMIT + 4;
    localparam int PSW        = $clog2(SCAN_BOUND + 2);

    t_state          r_state, n_state;
    logic [LGW-1:0]  r_lg, n_lg;
    logic [LGW-1:0]  r_sb, n_sb;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_addr, n_addr;
    logic [PSW-1:0]  r_passes, n_passes;
    logic [PID_W-1:0] r_query, n_query;
    t_out_beat       r_res, n_res;

    // RAM port
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [IDW-1:0]  w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [IDW-1:0]  w_rdata;

    // decision terms
    logic [LGW-1:0]  w_lg_inc;
    logic            w_lg_wrap;
    logic            w_need_scan;
    logic            w_full;
    logic            w_q_ok;
    logic [CW-1:0]   w_cnt_m1;
    logic [AW-1:0]   w_top_addr;
    logic [LGW-1:0]  w_p;
    logic            w_hit;
    logic            w_step_wrap;
    logic            w_restart;
    logic            w_last;
    logic            w_exhaust;
    logic            w_look_hit;
    logic            w_look_end;

    upa_ram #(
        .WIDTH (IDW),
        .DEPTH (TABLE_DEPTH)
    ) u_pid_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // conditions shared by next-state and datapath
    assign w_lg_inc    = r_lg + LGW'(1);
    assign w_lg_wrap   = w_lg_inc >= LGW'(PID_LIMIT);
    assign w_need_scan = w_lg_wrap || (w_lg_inc >= r_sb);
    assign w_full      = r_cnt == CW'(TABLE_DEPTH);
    assign w_q_ok      = (i_beat.query_pid != '0) && (32'(i_beat.query_pid) < PID_LIMIT);
    assign w_cnt_m1    = r_cnt - CW'(1);
    assign w_top_addr  = w_cnt_m1[AW-1:0];
    assign w_p         = LGW'(w_rdata);
    assign w_hit       = w_p == r_lg;
    assign w_step_wrap = w_lg_inc >= r_sb;
    assign w_restart   = w_hit && w_step_wrap;
    assign w_last      = r_addr == '0;
    assign w_exhaust   = r_passes >= PSW'(SCAN_BOUND);
    assign w_look_hit  = 32'(w_rdata) == 32'(r_query);
    assign w_look_end  = r_addr == w_top_addr;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_beat.req_type == REQ_LOOKUP) begin
                        n_state = (w_q_ok && r_cnt != '0) ? S_LOOK : S_DONE;
                    end else if (w_full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = w_need_scan ? S_PASS : S_COMMIT;
                    end
                end
            end
            S_PASS: begin
                if (w_exhaust) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (r_cnt == '0) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_restart) begin
                    n_state = S_PASS;
                end else if (w_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_LOOK: begin
                if (w_look_hit || w_look_end) begin
                    n_state = S_DONE;
                end
            end
            S_COMMIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath, RAM control and response
    always_comb begin
        n_lg     = r_lg;
        n_sb     = r_sb;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_passes = r_passes;
        n_query  = r_query;
        n_res    = r_res;
        w_we     = 1'b0;
        w_waddr  = r_cnt[AW-1:0];
        w_wdata  = IDW'(r_lg);
        w_raddr  = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_query = i_beat.query_pid;
                    n_res   = '0;
                    if (i_beat.req_type == REQ_LOOKUP) begin
                        // first slot is read right away
                        w_raddr = '0;
                        n_addr  = '0;
                        if (!(w_q_ok && r_cnt != '0)) begin
                            n_res.status = STAT_MISS;
                        end
                    end else if (w_full) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        n_lg = w_lg_wrap ? LGW'(1) : w_lg_inc;
                        if (w_need_scan) begin
                            n_sb     = LGW'(PID_LIMIT);
                            n_passes = '0;
                        end
                    end
                end
            end
            S_PASS: begin
                // open a pass from the newest slot down
                n_passes = r_passes + PSW'(1);
                if (w_exhaust) begin
                    n_res.status = STAT_FULL;
                end else begin
                    w_raddr = w_top_addr;
                    n_addr  = w_top_addr;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    if (w_step_wrap) begin
                        n_lg = w_lg_wrap ? LGW'(1) : w_lg_inc;
                        n_sb = LGW'(PID_LIMIT);
                    end else begin
                        n_lg = w_lg_inc;
                    end
                end else if (w_p > r_lg && r_sb > w_p) begin
                    n_sb = w_p;
                end
                if (!w_restart && !w_last) begin
                    w_raddr = r_addr - AW'(1);
                    n_addr  = r_addr - AW'(1);
                end
            end
            S_LOOK: begin
                if (w_look_hit) begin
                    n_res.status     = STAT_OK;
                    n_res.result_pid = r_query;
                    n_res.slot_index = SLOT_W'(32'(r_addr));
                end else if (w_look_end) begin
                    n_res.status = STAT_MISS;
                end else begin
                    w_raddr = r_addr + AW'(1);
                    n_addr  = r_addr + AW'(1);
                end
            end
            S_COMMIT: begin
                // store into the lowest free slot (slots fill in order)
                w_we             = 1'b1;
                n_cnt            = r_cnt + CW'(1);
                n_res.status     = STAT_OK;
                n_res.result_pid = PID_W'(32'(r_lg));
                n_res.slot_index = SLOT_W'(32'(r_cnt));
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lg     <= LGW'(PID_LIMIT);
            r_sb     <= LGW'(PID_LIMIT);
            r_cnt    <= '0;
            r_passes <= '0;
        end else begin
            r_state  <= n_state;
            r_lg     <= n_lg;
            r_sb     <= n_sb;
            r_cnt    <= n_cnt;
            r_passes <= n_passes;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_query <= n_query;
        r_res   <= n_res;
    end

    assign o_stat.idle      = r_state == S_IDLE;
    assign o_stat.res_valid = r_state == S_DONE;
    assign o_stat.res       = r_res;

endmodule

// ===== rtl/unique_pid_allocator.sv =====
// ----------------------------------------------------------------------------
// unique_pid_allocator
// Flow, accept to result beat: a lookup compares the table slots in order from slot 0;
// an empty table, a bad identifier or a full table go straight to the result; an
// allocate commits after any rescan passes, which walk the RAM one slot per cycle.
// One request in flight: the next beat is taken the cycle after the result enters
// the output register, so each request holds the input until its result is taken.
// Reset: synchronous; fill count cleared (table empty, no clearing pass), counters at limit.
// ----------------------------------------------------------------------------
module unique_pid_allocator #(
    parameter int TABLE_DEPTH = 64,
    parameter int PID_LIMIT   = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  upa_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output upa_pkg::t_out_beat o_out_beat
);
    import upa_pkg::*;

    t_ctrl_stat w_stat;
    logic       w_in_acc;
    logic       w_take;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out_beat;

    // input beat is taken only by an idle sequencer
    assign o_in_stall = !w_stat.idle;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    upa_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PID_LIMIT   (PID_LIMIT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_beat  (i_in_beat),
        .i_take  (w_take),
        .o_stat  (w_stat)
    );

    // output register: loads when empty or being drained
    assign w_take = w_stat.res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_beat <= w_stat.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // an accepted request keeps the input side closed next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a request");

    // a finished response is held while the output register is blocked
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_valid && r_out_valid && i_out_stall |=> w_stat.res_valid)
        else $error("response dropped while output register was blocked");

    // refused or missed requests carry zero identifier and slot
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != STAT_OK
        |-> o_out_beat.result_pid == '0 && o_out_beat.slot_index == '0)
        else $error("failed response carries nonzero fields");

    // no new request starts while a response is pending in the sequencer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_valid |-> o_in_stall)
        else $error("input open while a response is pending");

endmodule
